// ===== hw/rtl/prnesc_pkg.sv =====
// Shared types and constants for the printer escape command parser.
// Holds the parser state record, the event record, character and command
// codes, font-mode masks and reset values. No dependencies.
`default_nettype none

package prnesc_pkg;

  localparam int MAX_TAB_STOPS = 28;

  localparam logic [2:0] EV_CHAR      = 3'd0;
  localparam logic [2:0] EV_GRAPHICS  = 3'd1;
  localparam logic [2:0] EV_BACKSPACE = 3'd2;
  localparam logic [2:0] EV_FORMFEED  = 3'd3;
  localparam logic [2:0] EV_FEED      = 3'd4;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_SO  = 8'd14;
  localparam logic [7:0] CH_SI  = 8'd15;
  localparam logic [7:0] CH_DC2 = 8'd18;
  localparam logic [7:0] CH_DC4 = 8'd20;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [7:0] CMD_NONE      = 8'h00;
  localparam logic [7:0] CMD_UNDERLINE = 8'h2D;
  localparam logic [7:0] CMD_SP_27     = 8'h30;
  localparam logic [7:0] CMD_SP_21     = 8'h31;
  localparam logic [7:0] CMD_SP_36     = 8'h32;
  localparam logic [7:0] CMD_SP_N      = 8'h33;
  localparam logic [7:0] CMD_ITAL_ON   = 8'h34;
  localparam logic [7:0] CMD_ITAL_OFF  = 8'h35;
  localparam logic [7:0] CMD_INIT      = 8'h40;
  localparam logic [7:0] CMD_SP_3N     = 8'h41;
  localparam logic [7:0] CMD_FORM_LEN  = 8'h43;
  localparam logic [7:0] CMD_TABS      = 8'h44;
  localparam logic [7:0] CMD_EMPH_ON   = 8'h45;
  localparam logic [7:0] CMD_EMPH_OFF  = 8'h46;
  localparam logic [7:0] CMD_DBL_ON    = 8'h47;
  localparam logic [7:0] CMD_DBL_OFF   = 8'h48;
  localparam logic [7:0] CMD_FEED      = 8'h4A;
  localparam logic [7:0] CMD_GFX_K     = 8'h4B;
  localparam logic [7:0] CMD_GFX_L     = 8'h4C;
  localparam logic [7:0] CMD_SKIP_N    = 8'h4E;
  localparam logic [7:0] CMD_COLUMNS   = 8'h51;
  localparam logic [7:0] CMD_SCRIPT    = 8'h53;
  localparam logic [7:0] CMD_SCRIPT_OFF = 8'h54;
  localparam logic [7:0] CMD_SKIP_U    = 8'h55;
  localparam logic [7:0] CMD_WIDE      = 8'h57;
  localparam logic [7:0] CMD_GFX_Y     = 8'h59;
  localparam logic [7:0] CMD_GFX_Z     = 8'h5A;
  localparam logic [7:0] CMD_FEED_REV  = 8'h6A;
  localparam logic [7:0] CMD_SKIP_L    = 8'h6C;

  localparam logic [8:0] FM_UNDERLINE = 9'h001;
  localparam logic [8:0] FM_ITALIC    = 9'h002;
  localparam logic [8:0] FM_EMPH      = 9'h004;
  localparam logic [8:0] FM_DOUBLE    = 9'h008;
  localparam logic [8:0] FM_SUPER     = 9'h010;
  localparam logic [8:0] FM_SUB       = 9'h020;
  localparam logic [8:0] FM_EXPANDED  = 9'h040;
  localparam logic [8:0] FM_SOWIDE    = 9'h080;
  localparam logic [8:0] FM_COMPRESS  = 9'h100;

  localparam logic [9:0] SPACING_RESET = 10'd36;
  localparam logic [9:0] SPACING_27    = 10'd27;
  localparam logic [9:0] SPACING_21    = 10'd21;
  localparam logic [7:0] COLUMNS_RESET = 8'd80;

  localparam logic [1:0] DENS_SINGLE = 2'd0;
  localparam logic [1:0] DENS_DOUBLE = 2'd1;
  localparam logic [1:0] DENS_QUAD   = 2'd2;

  typedef struct packed {
    logic        esc;
    logic [7:0]  cmd;
    logic [11:0] cnt;
    logic [7:0]  first;
    logic [2:0]  second;
    logic [10:0] glen;
    logic [8:0]  modes;
    logic [9:0]  spacing;
    logic [7:0]  columns;
    logic [1:0]  density;
  } st_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] value;
  } ev_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prnesc_decode.sv =====
// Combinational byte decoder of the printer escape command parser.
// Maps the current parser state and one data byte to the next state and
// an optional print event. Depends on prnesc_pkg.
`default_nettype none

module prnesc_decode (
  input  wire logic [7:0]      data_byte,
  input  prnesc_pkg::st_t      st,
  output prnesc_pkg::st_t      st_nxt,
  output prnesc_pkg::ev_t      ev
);

  logic [7:0]  cmd;
  logic [11:0] cnt;
  logic [7:0]  fa;
  logic [2:0]  sa;
  logic        done;
  logic        has_arg;

  always_comb begin
    st_nxt   = st;
    ev.valid = 1'b0;
    ev.kind  = prnesc_pkg::EV_CHAR;
    ev.value = 8'd0;
    done     = 1'b0;
    cmd      = st.cmd;
    cnt      = st.cnt + 12'd1;
    if (st.cmd == prnesc_pkg::CMD_NONE) begin
      cmd = data_byte;
      cnt = 12'd0;
    end
    fa      = (cnt == 12'd1) ? data_byte : st.first;
    sa      = (cnt == 12'd2) ? data_byte[2:0] : st.second;
    has_arg = (cnt != 12'd0);

    if (st.esc) begin
      st_nxt.cmd    = cmd;
      st_nxt.cnt    = cnt;
      st_nxt.first  = fa;
      st_nxt.second = sa;
      case (cmd)
        prnesc_pkg::CMD_UNDERLINE: begin
          if (has_arg) begin
            st_nxt.modes = (fa != 8'd0) ? (st.modes | prnesc_pkg::FM_UNDERLINE)
                                        : (st.modes & ~prnesc_pkg::FM_UNDERLINE);
            done = 1'b1;
          end
        end
        prnesc_pkg::CMD_SP_27: begin
          st_nxt.spacing = prnesc_pkg::SPACING_27;
          done = 1'b1;
        end
        prnesc_pkg::CMD_SP_21: begin
          st_nxt.spacing = prnesc_pkg::SPACING_21;
          done = 1'b1;
        end
        prnesc_pkg::CMD_SP_36: begin
          st_nxt.spacing = prnesc_pkg::SPACING_RESET;
          done = 1'b1;
        end
        prnesc_pkg::CMD_SP_N: begin
          if (has_arg) begin
            st_nxt.spacing = {2'b00, fa};
            done = 1'b1;
          end
        end
        prnesc_pkg::CMD_SP_3N: begin
          if (has_arg) begin
            st_nxt.spacing = {2'b00, fa} + {1'b0, fa, 1'b0};
            done = 1'b1;
          end
        end
        prnesc_pkg::CMD_ITAL_ON: begin
          st_nxt.modes = st.modes | prnesc_pkg::FM_ITALIC;
          done = 1'b1;
        end
        prnesc_pkg::CMD_ITAL_OFF: begin
          st_nxt.modes = st.modes & ~prnesc_pkg::FM_ITALIC;
          done = 1'b1;
        end
        prnesc_pkg::CMD_INIT: begin
          st_nxt.spacing = prnesc_pkg::SPACING_RESET;
          st_nxt.columns = prnesc_pkg::COLUMNS_RESET;
          st_nxt.density = prnesc_pkg::DENS_SINGLE;
          st_nxt.modes   = 9'd0;
          done = 1'b1;
        end
        prnesc_pkg::CMD_FORM_LEN: begin
          done = ((cnt == 12'd1) && (fa != 8'd0)) || (cnt == 12'd2);
        end
        prnesc_pkg::CMD_TABS: begin
          done = (data_byte[6:0] == 7'd0) || (cnt > 12'(prnesc_pkg::MAX_TAB_STOPS));
        end
        prnesc_pkg::CMD_EMPH_ON: begin
          st_nxt.modes = st.modes | prnesc_pkg::FM_EMPH;
          done = 1'b1;
        end
        prnesc_pkg::CMD_EMPH_OFF: begin
          st_nxt.modes = st.modes & ~prnesc_pkg::FM_EMPH;
          done = 1'b1;
        end
        prnesc_pkg::CMD_DBL_ON: begin
          st_nxt.modes = st.modes | prnesc_pkg::FM_DOUBLE;
          done = 1'b1;
        end
        prnesc_pkg::CMD_DBL_OFF: begin
          st_nxt.modes = st.modes & ~(prnesc_pkg::FM_DOUBLE | prnesc_pkg::FM_SUPER |
                                      prnesc_pkg::FM_SUB);
          done = 1'b1;
        end
        prnesc_pkg::CMD_FEED, prnesc_pkg::CMD_FEED_REV: begin
          if (has_arg) begin
            ev.valid = 1'b1;
            ev.kind  = prnesc_pkg::EV_FEED;
            ev.value = fa;
            done = 1'b1;
          end
        end
        prnesc_pkg::CMD_GFX_K, prnesc_pkg::CMD_GFX_L,
        prnesc_pkg::CMD_GFX_Y, prnesc_pkg::CMD_GFX_Z: begin
          if (cnt == 12'd2) begin
            if (cmd == prnesc_pkg::CMD_GFX_K) begin
              st_nxt.density = prnesc_pkg::DENS_SINGLE;
            end else if (cmd == prnesc_pkg::CMD_GFX_Z) begin
              st_nxt.density = prnesc_pkg::DENS_QUAD;
            end else begin
              st_nxt.density = prnesc_pkg::DENS_DOUBLE;
            end
            st_nxt.glen = {sa, fa};
            done = ({sa, fa} == 11'd0);
          end else if (cnt >= 12'd3) begin
            ev.valid = 1'b1;
            ev.kind  = prnesc_pkg::EV_GRAPHICS;
            ev.value = data_byte;
            done = ((cnt - 12'd2) >= {1'b0, st.glen});
          end
        end
        prnesc_pkg::CMD_SKIP_N, prnesc_pkg::CMD_SKIP_U, prnesc_pkg::CMD_SKIP_L: begin
          done = has_arg;
        end
        prnesc_pkg::CMD_COLUMNS: begin
          if (has_arg) begin
            st_nxt.columns = fa;
            done = 1'b1;
          end
        end
        prnesc_pkg::CMD_SCRIPT: begin
          if (has_arg) begin
            st_nxt.modes = (fa != 8'd0) ? (st.modes | prnesc_pkg::FM_SUB)
                                        : (st.modes | prnesc_pkg::FM_SUPER);
            done = 1'b1;
          end
        end
        prnesc_pkg::CMD_SCRIPT_OFF: begin
          st_nxt.modes = st.modes & ~(prnesc_pkg::FM_SUPER | prnesc_pkg::FM_SUB);
          done = 1'b1;
        end
        prnesc_pkg::CMD_WIDE: begin
          if (has_arg) begin
            st_nxt.modes = (fa != 8'd0) ? (st.modes | prnesc_pkg::FM_EXPANDED)
                           : (st.modes & ~(prnesc_pkg::FM_EXPANDED | prnesc_pkg::FM_SOWIDE));
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        st_nxt.esc    = 1'b0;
        st_nxt.cmd    = prnesc_pkg::CMD_NONE;
        st_nxt.cnt    = 12'd0;
        st_nxt.first  = 8'd0;
        st_nxt.second = 3'd0;
        st_nxt.glen   = 11'd0;
      end
    end else begin
      case (data_byte)
        prnesc_pkg::CH_BS: begin
          ev.valid = 1'b1;
          ev.kind  = prnesc_pkg::EV_BACKSPACE;
        end
        prnesc_pkg::CH_FF: begin
          ev.valid = 1'b1;
          ev.kind  = prnesc_pkg::EV_FORMFEED;
        end
        prnesc_pkg::CH_SO:  st_nxt.modes = st.modes | prnesc_pkg::FM_SOWIDE;
        prnesc_pkg::CH_SI:  st_nxt.modes = st.modes | prnesc_pkg::FM_COMPRESS;
        prnesc_pkg::CH_DC2: st_nxt.modes = st.modes & ~prnesc_pkg::FM_COMPRESS;
        prnesc_pkg::CH_DC4: st_nxt.modes = st.modes & ~prnesc_pkg::FM_SOWIDE;
        prnesc_pkg::CH_ESC: st_nxt.esc = 1'b1;
        default: begin
          if (data_byte >= prnesc_pkg::CH_SPACE) begin
            ev.valid = 1'b1;
            ev.kind  = prnesc_pkg::EV_CHAR;
            ev.value = data_byte;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/printer_escape_command_parser.sv =====
// Output: the event of a beat appears on the output in the cycle after the beat is accepted.
// Throughput: one input beat per cycle; the single output register limits the rate only
// while the output side stalls, and a byte that makes no event is accepted at that rate too.
// Reset (rst_n low, synchronous): no command in progress, fonts cleared, spacing 36,
// column limit 80, single density, output empty. Depends on prnesc_pkg, prnesc_decode.
`default_nettype none

module printer_escape_command_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_event_kind,
  output logic [7:0]      out_event_value,
  output logic [8:0]      out_mode_bits,
  output logic [9:0]      out_spacing_now,
  output logic [1:0]      out_density_now,
  output logic [7:0]      out_columns_now
);

  prnesc_pkg::st_t st_r;
  prnesc_pkg::st_t st_nxt;
  prnesc_pkg::ev_t ev;

  logic       out_valid_r;
  logic [2:0] kind_r;
  logic [7:0] value_r;
  logic [8:0] modes_r;
  logic [9:0] spacing_r;
  logic [1:0] density_r;
  logic [7:0] columns_r;
  logic       in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  prnesc_decode u_decode (
    .data_byte (in_data_byte),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.esc     <= 1'b0;
      st_r.cmd     <= prnesc_pkg::CMD_NONE;
      st_r.cnt     <= 12'd0;
      st_r.first   <= 8'd0;
      st_r.second  <= 3'd0;
      st_r.glen    <= 11'd0;
      st_r.modes   <= 9'd0;
      st_r.spacing <= prnesc_pkg::SPACING_RESET;
      st_r.columns <= prnesc_pkg::COLUMNS_RESET;
      st_r.density <= prnesc_pkg::DENS_SINGLE;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire) begin
        out_valid_r <= ev.valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && ev.valid) begin
      kind_r    <= ev.kind;
      value_r   <= ev.value;
      modes_r   <= st_nxt.modes;
      spacing_r <= st_nxt.spacing;
      density_r <= st_nxt.density;
      columns_r <= st_nxt.columns;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_event_value = value_r;
  assign out_mode_bits   = modes_r;
  assign out_spacing_now = spacing_r;
  assign out_density_now = density_r;
  assign out_columns_now = columns_r;

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.esc |-> (st_r.cmd == prnesc_pkg::CMD_NONE) && (st_r.cnt == 12'd0))
    else $error("parser idle with command fields not cleared");

  a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.density != 2'd3)
    else $error("graphics density holds an unused code");

  a_long_cmd_is_gfx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cnt > 12'd29) |-> (st_r.cmd == prnesc_pkg::CMD_GFX_K ||
      st_r.cmd == prnesc_pkg::CMD_GFX_L || st_r.cmd == prnesc_pkg::CMD_GFX_Y ||
      st_r.cmd == prnesc_pkg::CMD_GFX_Z))
    else $error("argument count ran past tab limit outside graphics");

  a_no_event_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ev.valid) |=> !out_valid_r)
    else $error("output raised for a beat that made no event");
`endif

endmodule

`default_nettype wire
